// ----- sv/dre_pkg.sv -----
// Shared types and constants for the delta/run-length encoder.
// No dependencies; every other file of the block imports this package.
package dre_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int COUNT_WIDTH  = 16;
    localparam int DELTA_WIDTH  = SAMPLE_WIDTH + 1;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_WIDTH   = $clog2(QUEUE_DEPTH);

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic signed [DELTA_WIDTH-1:0]  delta_t;
    typedef logic        [COUNT_WIDTH-1:0]  count_t;
    typedef logic        [QPTR_WIDTH-1:0]   qptr_t;
    typedef logic        [QPTR_WIDTH:0]     qcount_t;

    localparam count_t COUNT_MAX = '1;

    // One element handed from the front to the back.
    typedef struct packed {
        delta_t delta;
        logic   eos;
    } elem_t;

    // Queue status seen by the front.
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // Back-end status, visible at the top level.
    typedef struct packed {
        logic run_open;
        logic flush_pending;
    } back_status_t;

endpackage

// ----- sv/dre_if.sv -----
// Valid/ready channel interfaces for samples in and run pairs out.
// Depends on dre_pkg.
interface dre_sample_if
    import dre_pkg::*;
();
    logic    valid;
    logic    ready;
    sample_t sample;
    logic    end_of_stream;

    modport source (output valid, output sample, output end_of_stream, input ready);
    modport sink   (input valid, input sample, input end_of_stream, output ready);
endinterface

interface dre_pair_if
    import dre_pkg::*;
();
    logic   valid;
    logic   ready;
    delta_t run_delta;
    count_t run_length;
    logic   final_pair;

    modport source (output valid, output run_delta, output run_length, output final_pair,
                    input ready);
    modport sink   (input valid, input run_delta, input run_length, input final_pair,
                    output ready);
endinterface

// ----- sv/dre_front.sv -----
// Front end: accepts samples and turns them into delta elements.
// Depends on dre_pkg and dre_if.
module dre_front
    import dre_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    dre_sample_if.sink    samples,
    input  q_status_t     q_status,
    output logic          push,
    output elem_t         push_elem
);

    logic    have_prev_reg;
    logic    have_prev_next;
    sample_t prev_reg;
    sample_t prev_next;
    delta_t  cur_wide;
    delta_t  prev_wide;

    assign samples.ready = !q_status.full;
    assign push          = samples.valid && samples.ready;

    always_comb
    begin
        cur_wide        = DELTA_WIDTH'(samples.sample);
        prev_wide       = DELTA_WIDTH'(prev_reg);
        push_elem.delta = have_prev_reg ? delta_t'(cur_wide - prev_wide) : cur_wide;
        push_elem.eos   = samples.end_of_stream;
        have_prev_next  = have_prev_reg;
        prev_next       = prev_reg;
        if (push)
        begin
            // drop history at end of stream
            have_prev_next = !samples.end_of_stream;
            prev_next      = samples.sample;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_prev_reg <= 1'b0;
            prev_reg      <= '0;
        end
        else
        begin
            have_prev_reg <= have_prev_next;
            prev_reg      <= prev_next;
        end
    end

endmodule

// ----- sv/dre_queue.sv -----
// Short element queue between front and back end.
// Depends on dre_pkg.
module dre_queue
    import dre_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  elem_t     push_elem,
    input  logic      pop,
    output elem_t     head,
    output logic      head_valid,
    output q_status_t q_status
);

    elem_t   mem_reg [QUEUE_DEPTH];
    qptr_t   wr_ptr_reg;
    qptr_t   wr_ptr_next;
    qptr_t   rd_ptr_reg;
    qptr_t   rd_ptr_next;
    qcount_t count_reg;
    qcount_t count_next;

    assign head           = mem_reg[rd_ptr_reg];
    assign head_valid     = (count_reg != '0);
    assign q_status.empty = (count_reg == '0);
    assign q_status.full  = (count_reg == (QPTR_WIDTH+1)'(QUEUE_DEPTH));

    always_comb
    begin
        wr_ptr_next = push ? qptr_t'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop  ? qptr_t'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = qcount_t'(count_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            count_next = qcount_t'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_elem;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- sv/dre_back.sv -----
// Back end: merges equal elements into runs and emits pairs from an output register.
// Depends on dre_pkg and dre_if.
module dre_back
    import dre_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  elem_t        head,
    input  logic         head_valid,
    output logic         pop,
    output back_status_t status,
    dre_pair_if.source   pairs
);

    logic   run_open_reg;
    logic   run_open_next;
    delta_t run_delta_reg;
    delta_t run_delta_next;
    count_t run_len_reg;
    count_t run_len_next;
    logic   flush_pending_reg;
    logic   flush_pending_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    delta_t out_delta_reg;
    delta_t out_delta_next;
    count_t out_len_reg;
    count_t out_len_next;
    logic   out_final_reg;
    logic   out_final_next;

    logic   merge;
    logic   split;
    logic   need_out;
    logic   can_load;

    assign pairs.valid      = out_valid_reg;
    assign pairs.run_delta  = out_delta_reg;
    assign pairs.run_length = out_len_reg;
    assign pairs.final_pair = out_final_reg;

    assign status.run_open      = run_open_reg;
    assign status.flush_pending = flush_pending_reg;

    always_comb
    begin
        merge    = run_open_reg && (run_delta_reg == head.delta) && (run_len_reg != COUNT_MAX);
        split    = run_open_reg && !merge;
        need_out = split || head.eos;
        can_load = !out_valid_reg || pairs.ready;
        pop      = head_valid && !flush_pending_reg && (can_load || !need_out);

        run_open_next      = run_open_reg;
        run_delta_next     = run_delta_reg;
        run_len_next       = run_len_reg;
        flush_pending_next = flush_pending_reg;
        out_valid_next     = out_valid_reg && !pairs.ready;
        out_delta_next     = out_delta_reg;
        out_len_next       = out_len_reg;
        out_final_next     = out_final_reg;

        if (flush_pending_reg && can_load)
        begin
            // second pair of an end-of-stream element
            out_valid_next     = 1'b1;
            out_delta_next     = run_delta_reg;
            out_len_next       = run_len_reg;
            out_final_next     = 1'b1;
            run_open_next      = 1'b0;
            flush_pending_next = 1'b0;
        end
        else if (pop)
        begin
            if (merge)
            begin
                run_len_next = count_t'(run_len_reg + 1'b1);
            end
            else
            begin
                run_open_next  = 1'b1;
                run_delta_next = head.delta;
                run_len_next   = count_t'(1);
            end

            if (split)
            begin
                out_valid_next     = 1'b1;
                out_delta_next     = run_delta_reg;
                out_len_next       = run_len_reg;
                out_final_next     = 1'b0;
                flush_pending_next = head.eos;
            end
            else if (head.eos)
            begin
                out_valid_next = 1'b1;
                out_delta_next = run_delta_next;
                out_len_next   = run_len_next;
                out_final_next = 1'b1;
                run_open_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        run_delta_reg <= run_delta_next;
        run_len_reg   <= run_len_next;
        out_delta_reg <= out_delta_next;
        out_len_reg   <= out_len_next;
        out_final_reg <= out_final_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_open_reg      <= 1'b0;
            flush_pending_reg <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            run_open_reg      <= run_open_next;
            flush_pending_reg <= flush_pending_next;
            out_valid_reg     <= out_valid_next;
        end
    end

endmodule

// ----- sv/delta_rle_encoder_top.sv -----
// Top level of the delta/run-length encoder: front end, element queue, back end.
// Depends on dre_pkg, dre_if, dre_front, dre_queue and dre_back.
//
//   channel   dir   payload                                  handshake
//   -------   ---   --------------------------------------   -----------
//   samples   in    sample[15:0] signed, end_of_stream       valid/ready
//   pairs     out   run_delta[16:0] signed, run_length[15:0], valid/ready
//                   final_pair
//
// Throughput is one item per cycle unless output stalls or a pending flush
// hold it. A sample passes a queue entry, then the back end's output register,
// for the pair it closes. An end-of-stream item that ends a run and flushes
// a new one gives two pairs; the back end pops no more until the second is
// loaded. Reset is asynchronous and returns the block to the start of a
// stream. Output stalls fill the four-entry queue before samples.ready drops.
module delta_rle_encoder_top
    import dre_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    dre_sample_if.sink  samples,
    dre_pair_if.source  pairs
);

    logic         push;
    elem_t        push_elem;
    logic         pop;
    elem_t        head;
    logic         head_valid;
    q_status_t    q_status;
    back_status_t back_status;

    // Front: form the delta against the previous sample of the stream.
    dre_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (samples),
        .q_status  (q_status),
        .push      (push),
        .push_elem (push_elem)
    );

    // Queue: decouple delta forming from run merging.
    dre_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_elem  (push_elem),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .q_status   (q_status)
    );

    // Back: merge runs and emit pairs.
    dre_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .status     (back_status),
        .pairs      (pairs)
    );

`ifndef SYNTHESIS
    // A pending flush always sits behind a pair already on the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        back_status.flush_pending |-> pairs.valid)
        else $error("flush pending without an output pair");

    // A pending flush always has an open run to flush.
    assert property (@(posedge clk) disable iff (!rst_n)
        back_status.flush_pending |-> back_status.run_open)
        else $error("flush pending with no open run");

    // Every emitted pair has a nonzero length.
    assert property (@(posedge clk) disable iff (!rst_n)
        pairs.valid |-> (pairs.run_length != '0))
        else $error("pair with zero run length");

    // The back end never pops an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("pop from empty queue");
`endif

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for delta_rle_encoder_top: drives sample streams and checks
// every run pair against an in-bench delta/run-length predictor.
// Depends on dre_pkg, dre_if (dre_sample_if, dre_pair_if) and the block's RTL.
module testbench;
    import dre_pkg::*;

    // Expected run pair, one per output item
    typedef struct {
        delta_t run_delta;
        count_t run_length;
        logic   final_pair;
    } run_pair_t;

    logic clk;
    logic rst_n;

    dre_sample_if samples();
    dre_pair_if   pairs();

    delta_rle_encoder_top u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples),
        .pairs   (pairs)
    );

    // Encoder state as the predictor sees it
    logic      seen_sample;
    sample_t   last_sample;
    logic      run_active;
    delta_t    run_value;
    count_t    run_count;

    run_pair_t expected_pairs[$];
    int        error_count;

    // Idle odds in percent, changed per test
    int        gap_percent;
    int        stall_percent;

    // 20-unit clock period
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Hard stop: generous against the slowest legal run (long gaps plus long stalls)
    initial
    begin
        #4_000_000;
        $display("Verification failed");
        $finish;
    end

    // Print one line per mismatch and count it
    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        error_count++;
    endtask

    // Idle length: present with the given odds in percent, mostly short, now and then long
    function automatic int idle_length(input int percent);
        if ($urandom_range(0, 99) >= percent)
            return 0;
        if ($urandom_range(0, 9) != 0)
            return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    function automatic void clear_encoder_state();
        seen_sample = 1'b0;
        last_sample = '0;
        run_active  = 1'b0;
        run_value   = '0;
        run_count   = '0;
    endfunction

    function automatic void push_pair(input delta_t d, input count_t n, input logic fin);
        run_pair_t p;
        p.run_delta  = d;
        p.run_length = n;
        p.final_pair = fin;
        expected_pairs.push_back(p);
    endfunction

    // Predict the pairs that one accepted sample releases
    function automatic void encode_sample(input sample_t s, input logic eos);
        delta_t elem;
        // First sample passes through sign-extended; later ones become differences
        if (seen_sample)
            elem = {s[SAMPLE_WIDTH-1], s} - {last_sample[SAMPLE_WIDTH-1], last_sample};
        else
            elem = {s[SAMPLE_WIDTH-1], s};
        last_sample = s;
        seen_sample = 1'b1;

        // Extend the open run unless the element differs or the count is saturated
        if (run_active && run_value == elem && run_count != COUNT_MAX)
            run_count++;
        else
        begin
            if (run_active)
                push_pair(run_value, run_count, 1'b0);
            run_active = 1'b1;
            run_value  = elem;
            run_count  = count_t'(1);
        end

        // Flush the open run and return to the start of a stream
        if (eos)
        begin
            push_pair(run_value, run_count, 1'b1);
            clear_encoder_state();
        end
    endfunction

    // Send one item. Called at a falling edge, returns at a falling edge.
    // Valid stays high between back-to-back items, so no glitch on it.
    task automatic send_sample(input sample_t s, input logic eos);
        int gap;
        gap = idle_length(gap_percent);
        if (gap > 0)
        begin
            samples.valid = 1'b0;
            repeat (gap)
            begin
                // Toggle the idle payload so the block must ignore it
                samples.sample        = sample_t'($urandom);
                samples.end_of_stream = 1'($urandom_range(0, 1));
                @(negedge clk);
            end
        end
        samples.valid         = 1'b1;
        samples.sample        = s;
        samples.end_of_stream = eos;
        // Hold until the block takes the item
        do
            @(posedge clk);
        while (!samples.ready);
        encode_sample(s, eos);
        @(negedge clk);
    endtask

    // Random streams shaped to build runs: mostly steady steps, some zero
    // deltas, step changes, full-range jumps and extreme values.
    task automatic run_random_streams(input int item_total);
        int      sent;
        int      len;
        int      r;
        sample_t cur;
        sample_t step;
        sent = 0;
        while (sent < item_total)
        begin
            r = $urandom_range(0, 9);
            if (r == 0)
                len = 1;
            else if (r == 1)
                len = $urandom_range(20, 50);
            else
                len = $urandom_range(2, 14);
            step = ($urandom_range(0, 3) == 0) ? sample_t'($urandom)
                                               : sample_t'($urandom_range(0, 8) - 4);
            cur  = ($urandom_range(0, 4) == 0) ? step : sample_t'($urandom);
            for (int i = 0; i < len; i++)
            begin
                if (i > 0)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 55)
                        cur = cur + step;
                    else if (r < 68)
                        cur = cur;
                    else if (r < 80)
                    begin
                        step = sample_t'($urandom_range(0, 8) - 4);
                        cur  = cur + step;
                    end
                    else if (r < 92)
                        cur = sample_t'($urandom);
                    else
                    begin
                        case ($urandom_range(0, 3))
                            0: cur = 16'h7fff;
                            1: cur = 16'h8000;
                            2: cur = 16'h0000;
                            default: cur = 16'hffff;
                        endcase
                    end
                end
                send_sample(cur, i == len - 1);
            end
            sent += len;
        end
    endtask

    // Extremes, single-sample streams, run merging and the double flush
    task automatic test_extremes_and_runs();
        gap_percent   = 30;
        stall_percent = 30;
        // single-sample streams
        send_sample(16'h7fff, 1'b1);
        send_sample(16'h8000, 1'b1);
        send_sample(16'h0000, 1'b1);
        // largest positive and negative deltas
        send_sample(16'h8000, 1'b0);
        send_sample(16'h7fff, 1'b1);
        send_sample(16'h7fff, 1'b0);
        send_sample(16'h8000, 1'b1);
        // alternating bit patterns
        send_sample(16'haaaa, 1'b0);
        send_sample(16'h5555, 1'b1);
        // first element merges with equal deltas
        send_sample(16'd5, 1'b0);
        send_sample(16'd10, 1'b0);
        send_sample(16'd15, 1'b1);
        // end of stream closes one run and flushes a new one
        send_sample(16'd1, 1'b0);
        send_sample(16'd2, 1'b0);
        send_sample(16'd2, 1'b1);
        // constant negative samples: raw value, then a zero-delta run
        send_sample(16'hffff, 1'b0);
        send_sample(16'hffff, 1'b0);
        send_sample(16'hffff, 1'b0);
        send_sample(16'hffff, 1'b1);
    endtask

    task automatic test_random_idle_mix();
        gap_percent   = 30;
        stall_percent = 30;
        run_random_streams(250);
    endtask

    // No idling on either side: one item per cycle unless the queue fills behind pending flushes
    task automatic test_full_rate();
        gap_percent   = 0;
        stall_percent = 0;
        run_random_streams(150);
    endtask

    // Heavy output stalls fill the queue and drop samples.ready
    task automatic test_output_backpressure();
        gap_percent   = 5;
        stall_percent = 75;
        run_random_streams(150);
    endtask

    // Output side: random stalls on pairs.ready, changed at the falling edge
    initial
    begin : pair_ready_driver
        int n;
        pairs.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            n = idle_length(stall_percent);
            if (n > 0)
            begin
                pairs.ready = 1'b0;
                repeat (n) @(negedge clk);
            end
            pairs.ready = 1'b1;
        end
    end

    // Compare each accepted pair with the oldest expectation
    always @(posedge clk)
    begin : check_pairs
        run_pair_t want;
        if (rst_n && pairs.valid && pairs.ready)
        begin
            if (expected_pairs.size() == 0)
                report_mismatch($sformatf("unexpected pair delta=%0d length=%0d final=%0b",
                                          pairs.run_delta, pairs.run_length,
                                          pairs.final_pair));
            else
            begin
                want = expected_pairs.pop_front();
                if (pairs.run_delta !== want.run_delta)
                    report_mismatch($sformatf("run_delta got %0d exp %0d",
                                              pairs.run_delta, want.run_delta));
                if (pairs.run_length !== want.run_length)
                    report_mismatch($sformatf("run_length got %0d exp %0d",
                                              pairs.run_length, want.run_length));
                if (pairs.final_pair !== want.final_pair)
                    report_mismatch($sformatf("final_pair got %0b exp %0b",
                                              pairs.final_pair, want.final_pair));
            end
        end
    end

    initial
    begin
        clk                   = 1'b0;
        rst_n                 = 1'b0;
        samples.valid         = 1'b0;
        samples.sample        = '0;
        samples.end_of_stream = 1'b0;
        error_count           = 0;
        gap_percent           = 0;
        stall_percent         = 0;
        clear_encoder_state();

        // Hold reset low, then release it at a falling edge
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_extremes_and_runs();
        test_random_idle_mix();
        test_full_rate();
        test_output_backpressure();

        samples.valid = 1'b0;

        // Drain: wait for every expected pair, then keep watching for stray pairs
        while (expected_pairs.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
